[rtl/core/waqm_pkg.sv]
// Shared types and constants for the wait and active queue manager.
// Used by waqm_ctrl, waqm_dp and the top level.
`default_nettype none

package waqm_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 16;
  localparam int YEARS_W = 8;
  localparam int ST_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ARRIVE = 3'd0,
    OP_ENTER  = 3'd1,
    OP_LEAVE  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SHOW   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_WAIT_EMPTY = 3'd1,
    ST_ACT_EMPTY  = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FULL       = 3'd4,
    ST_LISTED     = 3'd5,
    ST_NOTHING    = 3'd6
  } status_t;

  // kind of result the datapath loads into the output register
  typedef enum logic [3:0] {
    EMIT_NONE,
    EMIT_ARRIVE_OK,
    EMIT_FULL,
    EMIT_EMPTY_W,
    EMIT_EMPTY_A,
    EMIT_MOVED,
    EMIT_REMOVE,
    EMIT_LISTED,
    EMIT_NOTHING
  } emit_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SHOW_RD,
    S_SHOW_OUT
  } state_t;

  typedef struct packed {
    logic  load;       // latch the input item, select the list for the op (active for leave, else waiting)
    logic  rd_head;    // read head of selected list
    logic  arrive_wr;  // append latched entry to waiting list
    logic  move_wr;    // pop selected head, append read word to other list
    logic  sel_load_a; // switch to active list, reload remaining count
    logic  rd_rem;     // read selected list at remaining-1
    logic  rem_dec;
    logic  hit;        // record match position and hit flag
    logic  rd_shift;   // read selected list at pos+1
    logic  wr_shift;   // write read word at pos, advance pos
    logic  cnt_dec;    // shrink selected list
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            rem_zero;
    logic            match;
    logic            shift_more;
    logic            both_empty;
    logic            sel;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/waqm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module waqm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/waqm_ctrl.sv]
// Controller state machine for the wait and active queue manager.
// Depends on waqm_pkg; drives the datapath through cmd_t, reads sts_t.
`default_nettype none

module waqm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire waqm_pkg::sts_t  sts,
  output waqm_pkg::cmd_t       cmd
);
  import waqm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = EMIT_NONE;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (sts.op)
          OP_ARRIVE: begin
            if (sts.full) begin
              cmd.emit = EMIT_FULL;
            end else begin
              cmd.arrive_wr = 1'b1;
              cmd.emit      = EMIT_ARRIVE_OK;
            end
          end
          OP_ENTER: begin
            if (sts.rem_zero) begin
              cmd.emit = EMIT_EMPTY_W;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_MOVE;
            end
          end
          OP_LEAVE: begin
            if (sts.rem_zero) begin
              cmd.emit = EMIT_EMPTY_A;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_MOVE;
            end
          end
          OP_REMOVE: state_nxt = S_SRCH_RD;
          OP_SHOW:   state_nxt = S_SHOW_RD;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_MOVE: begin
        cmd.move_wr = 1'b1;
        cmd.emit    = EMIT_MOVED;
        state_nxt   = S_IDLE;
      end
      S_SRCH_RD: begin
        if (sts.rem_zero) begin
          if (!sts.sel) begin
            cmd.sel_load_a = 1'b1;
          end else begin
            cmd.emit  = EMIT_REMOVE;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.rd_rem = 1'b1;
          state_nxt  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = S_SHIFT_RD;
        end else begin
          cmd.rem_dec = 1'b1;
          state_nxt   = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.shift_more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          if (!sts.sel) begin
            cmd.sel_load_a = 1'b1;
            state_nxt      = S_SRCH_RD;
          end else begin
            cmd.emit  = EMIT_REMOVE;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_SHOW_RD: begin
        if (sts.rem_zero) begin
          if (!sts.sel) begin
            cmd.sel_load_a = 1'b1;
          end else begin
            if (sts.both_empty) begin
              cmd.emit = EMIT_NOTHING;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.rd_rem = 1'b1;
          state_nxt  = S_SHOW_OUT;
        end
      end
      S_SHOW_OUT: begin
        cmd.emit    = EMIT_LISTED;
        cmd.rem_dec = 1'b1;
        state_nxt   = S_SHOW_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/waqm_dp.sv]
// Datapath: two circular lists in RAM, heads, counts, search and shift
// pointers, and the result register. Depends on waqm_pkg and waqm_ram.
`default_nettype none

module waqm_dp #(
  parameter int CAPACITY = waqm_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = waqm_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [waqm_pkg::OP_W-1:0]     in_op,
  input  wire logic [waqm_pkg::KEY_W-1:0]    in_entry_key,
  input  wire logic [waqm_pkg::YEARS_W-1:0]  in_entry_years,
  input  wire waqm_pkg::cmd_t                cmd,
  output waqm_pkg::sts_t                     sts,
  output logic                               out_valid,
  output logic [waqm_pkg::ST_W-1:0]          out_status,
  output logic                               out_which_list,
  output logic [waqm_pkg::KEY_W-1:0]         out_shown_key,
  output logic [waqm_pkg::YEARS_W-1:0]       out_shown_years,
  output logic                               out_hit_waiting,
  output logic                               out_hit_active,
  output logic                               out_last_item
);
  import waqm_pkg::*;

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SKW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int DW  = SKW + YEARS_W;

  // base + offset around the ring; the sum stays below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0]      w_head_r, w_head_nxt, a_head_r, a_head_nxt;
  logic [CW-1:0]      w_cnt_r, w_cnt_nxt, a_cnt_r, a_cnt_nxt;
  logic [CW-1:0]      rem_r, rem_nxt, pos_r, pos_nxt;
  logic               sel_r, sel_nxt, hw_r, hw_nxt, ha_r, ha_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [SKW-1:0]     key_r, key_nxt;
  logic [YEARS_W-1:0] years_r, years_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]    out_status_r, out_status_nxt;
  logic               out_which_r, out_which_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [YEARS_W-1:0] out_years_r, out_years_nxt;
  logic               out_hw_r, out_hw_nxt, out_ha_r, out_ha_nxt;
  logic               out_last_r, out_last_nxt;

  logic [AW-1:0]      sel_head, rd_addr;
  logic [CW-1:0]      sel_cnt, rem_m1, pos_p1, rd_off;
  logic               rd_en;
  logic [DW-1:0]      w_rdata, a_rdata, rd_word;
  logic [SKW-1:0]     rd_key;
  logic [YEARS_W-1:0] rd_years;
  logic               w_we, a_we;
  logic [AW-1:0]      w_waddr, a_waddr;
  logic [DW-1:0]      w_wdata;
  logic               show_last;

  assign sel_head = sel_r ? a_head_r : w_head_r;
  assign sel_cnt  = sel_r ? a_cnt_r : w_cnt_r;
  assign rem_m1   = rem_r - CW'(1);
  assign pos_p1   = pos_r + CW'(1);

  always_comb begin
    rd_off = '0;
    if (cmd.rd_rem) begin
      rd_off = rem_m1;
    end else if (cmd.rd_shift) begin
      rd_off = pos_p1;
    end
  end

  assign rd_addr  = wrap(sel_head, rd_off);
  assign rd_en    = cmd.rd_head | cmd.rd_rem | cmd.rd_shift;
  assign rd_word  = sel_r ? a_rdata : w_rdata;
  assign rd_key   = rd_word[DW-1:YEARS_W];
  assign rd_years = rd_word[YEARS_W-1:0];

  // waiting list takes arrivals, leaves (active -> waiting) and its own shifts
  assign w_we    = cmd.arrive_wr | (cmd.move_wr & sel_r) | (cmd.wr_shift & ~sel_r);
  assign w_waddr = cmd.wr_shift ? wrap(w_head_r, pos_r) : wrap(w_head_r, w_cnt_r);
  assign w_wdata = cmd.arrive_wr ? {key_r, years_r} : rd_word;
  assign a_we    = (cmd.move_wr & ~sel_r) | (cmd.wr_shift & sel_r);
  assign a_waddr = cmd.wr_shift ? wrap(a_head_r, pos_r) : wrap(a_head_r, a_cnt_r);

  waqm_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_wait_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (w_rdata)
  );

  waqm_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_act_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (rd_word),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (a_rdata)
  );

  assign show_last = (rem_r == CW'(1)) && (sel_r || (a_cnt_r == '0));

  always_comb begin
    sts.op         = op_r;
    sts.full       = ((CW+1)'(w_cnt_r) + (CW+1)'(a_cnt_r)) >= (CW+1)'(CAPACITY);
    sts.rem_zero   = (rem_r == '0);
    sts.match      = (rd_key == key_r);
    sts.shift_more = (pos_p1 < sel_cnt);
    sts.both_empty = (w_cnt_r == '0) && (a_cnt_r == '0);
    sts.sel        = sel_r;
  end

  always_comb begin
    w_head_nxt = w_head_r;
    a_head_nxt = a_head_r;
    w_cnt_nxt  = w_cnt_r;
    a_cnt_nxt  = a_cnt_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    sel_nxt    = sel_r;
    hw_nxt     = hw_r;
    ha_nxt     = ha_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    years_nxt  = years_r;

    if (cmd.load) begin
      op_nxt    = in_op;
      key_nxt   = in_entry_key[SKW-1:0];
      years_nxt = in_entry_years;
      sel_nxt   = (in_op == OP_LEAVE);
      rem_nxt   = (in_op == OP_LEAVE) ? a_cnt_r : w_cnt_r;
      hw_nxt    = 1'b0;
      ha_nxt    = 1'b0;
    end
    if (cmd.arrive_wr) begin
      w_cnt_nxt = w_cnt_r + CW'(1);
    end
    if (cmd.move_wr) begin
      if (!sel_r) begin
        w_head_nxt = wrap(w_head_r, CW'(1));
        w_cnt_nxt  = w_cnt_r - CW'(1);
        a_cnt_nxt  = a_cnt_r + CW'(1);
      end else begin
        a_head_nxt = wrap(a_head_r, CW'(1));
        a_cnt_nxt  = a_cnt_r - CW'(1);
        w_cnt_nxt  = w_cnt_r + CW'(1);
      end
    end
    if (cmd.sel_load_a) begin
      sel_nxt = 1'b1;
      rem_nxt = a_cnt_r;
    end
    if (cmd.rem_dec) begin
      rem_nxt = rem_m1;
    end
    if (cmd.hit) begin
      pos_nxt = rem_m1;
      if (sel_r) begin
        ha_nxt = 1'b1;
      end else begin
        hw_nxt = 1'b1;
      end
    end
    if (cmd.wr_shift) begin
      pos_nxt = pos_p1;
    end
    if (cmd.cnt_dec) begin
      if (sel_r) begin
        a_cnt_nxt = a_cnt_r - CW'(1);
      end else begin
        w_cnt_nxt = w_cnt_r - CW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt  = (cmd.emit != EMIT_NONE);
    out_status_nxt = ST_OK;
    out_which_nxt  = 1'b0;
    out_key_nxt    = '0;
    out_years_nxt  = '0;
    out_hw_nxt     = 1'b0;
    out_ha_nxt     = 1'b0;
    out_last_nxt   = 1'b1;
    case (cmd.emit)
      EMIT_ARRIVE_OK: begin
        out_key_nxt   = KEY_W'(key_r);
        out_years_nxt = years_r;
      end
      EMIT_FULL: begin
        out_status_nxt = ST_FULL;
        out_key_nxt    = KEY_W'(key_r);
        out_years_nxt  = years_r;
      end
      EMIT_EMPTY_W: out_status_nxt = ST_WAIT_EMPTY;
      EMIT_EMPTY_A: out_status_nxt = ST_ACT_EMPTY;
      EMIT_MOVED: begin
        out_key_nxt   = KEY_W'(rd_key);
        out_years_nxt = rd_years;
      end
      EMIT_REMOVE: begin
        out_status_nxt = (hw_r || ha_r) ? ST_OK : ST_NOT_FOUND;
        out_key_nxt    = KEY_W'(key_r);
        out_hw_nxt     = hw_r;
        out_ha_nxt     = ha_r;
      end
      EMIT_LISTED: begin
        out_status_nxt = ST_LISTED;
        out_which_nxt  = sel_r;
        out_key_nxt    = KEY_W'(rd_key);
        out_years_nxt  = rd_years;
        out_last_nxt   = show_last;
      end
      EMIT_NOTHING: out_status_nxt = ST_NOTHING;
      default: out_last_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_head_r    <= '0;
      a_head_r    <= '0;
      w_cnt_r     <= '0;
      a_cnt_r     <= '0;
      rem_r       <= '0;
      pos_r       <= '0;
      sel_r       <= 1'b0;
      hw_r        <= 1'b0;
      ha_r        <= 1'b0;
      op_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      w_head_r    <= w_head_nxt;
      a_head_r    <= a_head_nxt;
      w_cnt_r     <= w_cnt_nxt;
      a_cnt_r     <= a_cnt_nxt;
      rem_r       <= rem_nxt;
      pos_r       <= pos_nxt;
      sel_r       <= sel_nxt;
      hw_r        <= hw_nxt;
      ha_r        <= ha_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    years_r      <= years_nxt;
    out_status_r <= out_status_nxt;
    out_which_r  <= out_which_nxt;
    out_key_r    <= out_key_nxt;
    out_years_r  <= out_years_nxt;
    out_hw_r     <= out_hw_nxt;
    out_ha_r     <= out_ha_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_which_list  = out_which_r;
  assign out_shown_key   = out_key_r;
  assign out_shown_years = out_years_r;
  assign out_hit_waiting = out_hw_r;
  assign out_hit_active  = out_ha_r;
  assign out_last_item   = out_last_r;

endmodule

`default_nettype wire

[rtl/core/wait_and_active_queue_manager.sv]
// Top level of the wait and active queue manager.
// Depends on waqm_pkg, waqm_ctrl and waqm_dp.
//
// Usage:
//  - Command channel: an item (in_op, in_entry_key, in_entry_years) is taken
//    at a clock edge where start is high and busy is low. One item at a time.
//  - Result channel: each result shows for one cycle with out_valid high;
//    out_last_item marks the final result of an item. The receiver cannot
//    stall, so results never wait.
//  - Arrive and failed enter/leave: the result register is loaded from the
//    execute state. Enter/leave that moves an entry adds a move state.
//  - Remove: each searched entry takes a read and a compare state, and the
//    shift of each newer entry a read and a write state, set by the one
//    registered RAM read port per list.
//  - Show: each listed entry takes a read state and an output state.
//  - Lists are rings in RAM with a head pointer, so enter and leave never
//    shift. Unknown op codes are dropped in the execute state, no result.
//  - Reset (rst_n low, synchronous) empties both lists; RAM contents are
//    not cleared, only entries below a count are ever read.
`default_nettype none

module wait_and_active_queue_manager #(
  parameter int CAPACITY = waqm_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = waqm_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [waqm_pkg::OP_W-1:0]     in_op,
  input  wire logic [waqm_pkg::KEY_W-1:0]    in_entry_key,
  input  wire logic [waqm_pkg::YEARS_W-1:0]  in_entry_years,
  output logic                               out_valid,
  output logic [waqm_pkg::ST_W-1:0]          out_status,
  output logic                               out_which_list,
  output logic [waqm_pkg::KEY_W-1:0]         out_shown_key,
  output logic [waqm_pkg::YEARS_W-1:0]       out_shown_years,
  output logic                               out_hit_waiting,
  output logic                               out_hit_active,
  output logic                               out_last_item
);
  import waqm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  waqm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  waqm_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_entry_key    (in_entry_key),
    .in_entry_years  (in_entry_years),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_which_list  (out_which_list),
    .out_shown_key   (out_shown_key),
    .out_shown_years (out_shown_years),
    .out_hit_waiting (out_hit_waiting),
    .out_hit_active  (out_hit_active),
    .out_last_item   (out_last_item)
  );

endmodule

`default_nettype wire
